// ----- hw/rtl/dfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_pkg: shared types and constants of the binary64 arithmetic unit
// Operation codes, result codes, controller commands, status and unpacking.
// ----------------------------------------------------------------------------
package dfa_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] CODE_LT = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] CODE_EQ = 64'h4000_0000_0000_0000;
	localparam logic [63:0] CODE_GT = 64'h4010_0000_0000_0000;
	localparam logic [63:0] CODE_UN = 64'hBFF0_0000_0000_0000;

	typedef logic signed [13:0] exp_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_UNPACK,
		CMD_PRENORM,
		CMD_ADD,
		CMD_MUL,
		CMD_DIV,
		CMD_FORM,
		CMD_NORM,
		CMD_DENORM,
		CMD_ROUND,
		CMD_EMIT
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_MUL,
		KIND_DIV
	} kind_t;

	typedef struct packed {
		logic  special;
		kind_t kind;
		logic  prenorm_done;
		logic  iter_done;
		logic  norm_done;
		logic  changed;
	} dfa_status_t;

	typedef struct packed {
		logic        sign;
		logic [10:0] exp;
		logic [52:0] man;
		logic        zero;
		logic        inf;
		logic        nan;
	} unpacked_t;

	function automatic unpacked_t unpack(input logic [63:0] x);
		unpacked_t u;
		u.sign = x[63];
		u.exp  = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
		u.man  = {(x[62:52] != 11'd0), x[51:0]};
		u.zero = (x[62:0] == 63'd0);
		u.inf  = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
		u.nan  = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
		return u;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dfa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_ctrl: sequencer of the binary64 arithmetic unit
// Steps the datapath through unpack, prenormalize, add or iterate, form, normalize, denormalize, round and emit.
// ----------------------------------------------------------------------------
module dfa_ctrl import dfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  dfa_status_t status,
	output cmd_t        cmd
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_UNPACK  = 11'b000_0000_0010,
		S_PRENORM = 11'b000_0000_0100,
		S_ADD     = 11'b000_0000_1000,
		S_MUL     = 11'b000_0001_0000,
		S_DIV     = 11'b000_0010_0000,
		S_FORM    = 11'b000_0100_0000,
		S_NORM    = 11'b000_1000_0000,
		S_DENORM  = 11'b001_0000_0000,
		S_ROUND   = 11'b010_0000_0000,
		S_EMIT    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   fire;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = (state_q == S_EMIT) && out_free && status.changed;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_UNPACK;
				end
			end
			S_UNPACK: begin
				cmd = CMD_UNPACK;
				if (status.special)
					state_d = S_EMIT;
				else if (status.kind == KIND_ADD)
					state_d = S_ADD;
				else
					state_d = S_PRENORM;
			end
			S_PRENORM: begin
				cmd = CMD_PRENORM;
				if (status.prenorm_done)
					state_d = (status.kind == KIND_MUL) ? S_MUL : S_DIV;
			end
			S_ADD: begin
				cmd     = CMD_ADD;
				state_d = S_NORM;
			end
			S_MUL: begin
				cmd = CMD_MUL;
				if (status.iter_done)
					state_d = S_FORM;
			end
			S_DIV: begin
				cmd = CMD_DIV;
				if (status.iter_done)
					state_d = S_FORM;
			end
			S_FORM: begin
				cmd     = CMD_FORM;
				state_d = S_NORM;
			end
			S_NORM: begin
				cmd = CMD_NORM;
				if (status.norm_done)
					state_d = S_DENORM;
			end
			S_DENORM: begin
				cmd     = CMD_DENORM;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd     = CMD_ROUND;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!status.changed)
					state_d = S_IDLE;
				else if (out_free) begin
					cmd     = CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (out_valid_q && out_stall) || fire;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dfa_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_dp: datapath of the binary64 arithmetic unit
// Operand registers, align/add, shift-add multiplier, restoring divider,
// normalizer, rounder and last-result compare.
// ----------------------------------------------------------------------------
module dfa_dp import dfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output dfa_status_t status,
	output logic [63:0] result_bits
);

	logic [2:0]   op_q;
	logic [63:0]  last_q;
	logic [63:0]  a_q, b_q;
	logic [52:0]  ma_q, mb_q;
	exp_t         ea_q, eb_q, e_q;
	logic         sign_q, st_q;
	logic [63:0]  m_q, res_q, out_q;
	logic [105:0] prod_q;
	logic [53:0]  rem_q;
	logic [5:0]   cnt_q;

	unpacked_t    ua, ub;
	logic         is_sub, sbe, sx;
	kind_t        kind;
	logic         spec;
	logic [63:0]  spec_bits;

	logic         swap, sgn_big, sgn_small;
	logic [10:0]  ebig, esmall, dexp;
	logic [52:0]  mbig, msmall;
	logic [63:0]  xw, yw, ys, asum;
	logic         ylost;

	logic [53:0]  acc;
	logic         rem_ge;
	logic [53:0]  rem_sub;

	exp_t         amt;
	logic [63:0]  dn_m;
	logic         dn_lost;

	logic         rnd_up;
	logic [10:0]  efield;
	logic [63:0]  rnd_bits;

	logic [63:0]  code, rv, rfinal;
	logic         rnan, same;

	assign ua     = unpack(a_q);
	assign ub     = unpack(b_q);
	assign is_sub = (op_q == OP_SUB) || (op_q == OP_CMP);
	assign sbe    = ub.sign ^ is_sub;
	assign sx     = ua.sign ^ ub.sign;

	always_comb begin
		unique case (op_q)
			OP_MUL:  kind = KIND_MUL;
			OP_DIV:  kind = KIND_DIV;
			default: kind = KIND_ADD;
		endcase
	end

	always_comb begin
		spec      = 1'b1;
		spec_bits = QNAN;
		case (kind)
			KIND_MUL: begin
				if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf))
					spec_bits = QNAN;
				else if (ua.inf || ub.inf)
					spec_bits = {sx, 11'h7FF, 52'd0};
				else if (ua.zero || ub.zero)
					spec_bits = {sx, 63'd0};
				else
					spec = 1'b0;
			end
			KIND_DIV: begin
				if (ua.nan || ub.nan || (ua.inf && ub.inf) || (ua.zero && ub.zero))
					spec_bits = QNAN;
				else if (ua.inf || ub.zero)
					spec_bits = {sx, 11'h7FF, 52'd0};
				else if (ua.zero || ub.inf)
					spec_bits = {sx, 63'd0};
				else
					spec = 1'b0;
			end
			default: begin
				if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != sbe)))
					spec_bits = QNAN;
				else if (ua.inf)
					spec_bits = {ua.sign, 11'h7FF, 52'd0};
				else if (ub.inf)
					spec_bits = {sbe, 11'h7FF, 52'd0};
				else if (ua.zero && ub.zero)
					spec_bits = {ua.sign & sbe, 63'd0};
				else
					spec = 1'b0;
			end
		endcase
	end

	// align and add
	always_comb begin
		swap      = {ub.exp, ub.man} > {ua.exp, ua.man};
		ebig      = swap ? ub.exp : ua.exp;
		esmall    = swap ? ua.exp : ub.exp;
		mbig      = swap ? ub.man : ua.man;
		msmall    = swap ? ua.man : ub.man;
		sgn_big   = swap ? sbe : ua.sign;
		sgn_small = swap ? ua.sign : sbe;
		dexp      = ebig - esmall;
		xw        = {1'b0, mbig, 10'd0};
		yw        = {1'b0, msmall, 10'd0};
		if (dexp >= 11'd64) begin
			ys    = 64'd0;
			ylost = |msmall;
		end else begin
			ys    = yw >> dexp[5:0];
			ylost = |(yw & ~({64{1'b1}} << dexp[5:0]));
		end
		asum = (sgn_big == sgn_small) ? xw + (ys | {63'd0, ylost})
		                              : xw - (ys | {63'd0, ylost});
	end

	assign acc     = {1'b0, prod_q[105:53]} + (mb_q[0] ? {1'b0, ma_q} : 54'd0);
	assign rem_ge  = rem_q >= {1'b0, mb_q};
	assign rem_sub = rem_ge ? rem_q - {1'b0, mb_q} : rem_q;

	always_comb begin
		amt = 14'sd1 - e_q;
		if (amt >= 14'sd64) begin
			dn_m    = 64'd0;
			dn_lost = |m_q;
		end else begin
			dn_m    = m_q >> amt[5:0];
			dn_lost = |(m_q & ~({64{1'b1}} << amt[5:0]));
		end
	end

	always_comb begin
		rnd_up = m_q[10] & ((|m_q[9:0]) | st_q | m_q[11]);
		efield = m_q[63] ? e_q[10:0] : 11'd0;
		if (m_q[63] && (e_q >= 14'sd2047))
			rnd_bits = {sign_q, 11'h7FF, 52'd0};
		else
			rnd_bits = {sign_q, efield, m_q[62:11]} + {63'd0, rnd_up};
	end

	always_comb begin
		if ((res_q[62:52] == 11'h7FF) && (res_q[51:0] != 52'd0))
			code = CODE_UN;
		else if (res_q[62:0] == 63'd0)
			code = CODE_EQ;
		else if (res_q[63])
			code = CODE_LT;
		else
			code = CODE_GT;
		rv     = (op_q == OP_CMP) ? code : res_q;
		rnan   = (rv[62:52] == 11'h7FF) && (rv[51:0] != 52'd0);
		rfinal = rnan ? QNAN : rv;
		same   = !rnan && (((rv[62:0] == 63'd0) && (last_q[62:0] == 63'd0)) || (rv == last_q));
	end

	assign status.special      = spec;
	assign status.kind         = kind;
	assign status.prenorm_done = ma_q[52] && mb_q[52];
	assign status.iter_done    = (kind == KIND_MUL) ? (cnt_q == 6'd52) : (cnt_q == 6'd63);
	assign status.norm_done    = m_q[63] || (e_q <= 14'sd1) || (m_q == 64'd0);
	assign status.changed      = !same;
	assign result_bits         = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_ADD;
			last_q <= 64'd0;
		end else begin
			if (cfg_we)
				op_q <= cfg_data;
			if (cmd == CMD_EMIT)
				last_q <= rfinal;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				a_q <= operand_a;
				b_q <= operand_b;
			end
			CMD_UNPACK: begin
				ma_q   <= ua.man;
				mb_q   <= ub.man;
				ea_q   <= $signed({3'b000, ua.exp});
				eb_q   <= $signed({3'b000, ub.exp});
				res_q  <= spec_bits;
				sign_q <= sx;
			end
			CMD_PRENORM: begin
				if (!ma_q[52]) begin
					ma_q <= {ma_q[51:0], 1'b0};
					ea_q <= ea_q - 14'sd1;
				end
				if (!mb_q[52]) begin
					mb_q <= {mb_q[51:0], 1'b0};
					eb_q <= eb_q - 14'sd1;
				end
				prod_q <= 106'd0;
				rem_q  <= {1'b0, ma_q};
				cnt_q  <= 6'd0;
			end
			CMD_ADD: begin
				m_q    <= asum;
				st_q   <= 1'b0;
				e_q    <= $signed({3'b000, ebig}) + 14'sd1;
				sign_q <= (asum == 64'd0) ? 1'b0 : sgn_big;
			end
			CMD_MUL: begin
				prod_q <= {acc, prod_q[52:1]};
				mb_q   <= {1'b0, mb_q[52:1]};
				cnt_q  <= cnt_q + 6'd1;
			end
			CMD_DIV: begin
				rem_q <= {rem_sub[52:0], 1'b0};
				m_q   <= {m_q[62:0], rem_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			CMD_FORM: begin
				if (kind == KIND_MUL) begin
					m_q  <= prod_q[105:42];
					st_q <= |prod_q[41:0];
					e_q  <= ea_q + eb_q - 14'sd1022;
				end else begin
					st_q <= (rem_q != 54'd0);
					e_q  <= ea_q - eb_q + 14'sd1023;
				end
			end
			CMD_NORM: begin
				if (!m_q[63] && (e_q > 14'sd1) && (m_q != 64'd0)) begin
					if ((m_q[63:48] == 16'd0) && (e_q > 14'sd16)) begin
						m_q <= {m_q[47:0], 16'd0};
						e_q <= e_q - 14'sd16;
					end else begin
						m_q <= {m_q[62:0], 1'b0};
						e_q <= e_q - 14'sd1;
					end
				end
			end
			CMD_DENORM: begin
				if (e_q < 14'sd1) begin
					m_q  <= dn_m;
					st_q <= st_q | dn_lost;
					e_q  <= 14'sd1;
				end
			end
			CMD_ROUND: res_q <= rnd_bits;
			CMD_EMIT:  out_q <= rfinal;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/double_float_alu.sv -----
`default_nettype none
// When NaN, infinity or zero operands decide the result, the item goes from unpack straight
// to emit; add, subtract and compare pass through align/add, multiply and divide through
// one-bit-per-cycle multiplier and divider iterations, then normalize, round and emit.
// One item at a time; the next item is accepted the cycle after a result is
// handed to the output register. Reset selects add and sets the last result to +0.0.
// ----------------------------------------------------------------------------
// double_float_alu: binary64 add, subtract, multiply, divide and compare
// Emits a result only when it differs from the last emitted value (+0.0 equals -0.0); a NaN is always emitted.
// ----------------------------------------------------------------------------
module double_float_alu import dfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  op_select,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bits
);

	cmd_t        cmd;
	dfa_status_t status;

	assign cfg_ready = 1'b1;

	dfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid),
		.cfg_data    (op_select),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.status      (status),
		.result_bits (result_bits)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not make the unit busy");

	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_bits[62:52] == 11'h7FF) && (result_bits[51:0] != 52'd0))
		|-> (result_bits == QNAN))
		else $error("non-canonical NaN emitted");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule
`default_nettype wire
